@@ src/mitt_pkg.sv @@
`timescale 1ns / 1ps
package mitt_pkg;
  localparam int MAX_TIMERS_DEF = 16;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_DEL = 2'd1;
  localparam logic [1:0] OP_DEL_ALL = 2'd2;
  localparam logic [1:0] OP_EXPIRE = 2'd3;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_DEL = 2'd1;
  localparam logic [1:0] KIND_FIRE = 2'd2;
  localparam logic [1:0] KIND_ARM = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_ARM = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;

  localparam logic [31:0] REPEAT_FOREVER = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0] owner;
    logic [31:0] period;
    logic [31:0] repeat_cnt;
  } entry_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
    logic [15:0] out_id;
    logic [7:0] out_owner;
    logic [1:0] arm_action;
    logic [31:0] delta_ms;
    logic last;
  } result_t;
endpackage

@@ src/mitt_divider.sv @@
`timescale 1ns / 1ps
module mitt_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);
  logic [31:0] quo;
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, divisor};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        quo  <= dividend;
        rem  <= '0;
        cnt  <= 6'd32;
      end else if (busy) begin
        if (!trial[32]) rem <= trial[31:0];
        else rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ src/multiplexed_interval_timer_table_core.sv @@
`timescale 1ns / 1ps
// Timer table of up to MAX_TIMERS entries sharing one countdown. The operation
// travels in s_tuser and the kind of each result in m_tuser. Items are handled
// one at a time and the input is not ready meanwhile. Expiry uses one shared
// 32-step restoring divider that computes elapsed time modulo each period in
// turn. Results leave through a one-deep output register, and an output stall
// holds the table walk. On expiry, fired timers come first, then the final
// countdown result with tlast high; add and delete each give one result, with
// tlast high.
module multiplexed_interval_timer_table_core #(
  parameter int MAX_TIMERS = mitt_pkg::MAX_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  // period_ms[31:0], repeat_req[63:32], owner[71:64], timer_id[87:72]
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // kind[1:0]
  output logic [1:0]  m_tuser,
  // status[1:0], out_id[17:2], out_owner[25:18], arm_action[27:26],
  // delta_ms[59:28]
  output logic [63:0] m_tdata,
  output logic        m_tlast
);
  localparam int IW = $clog2(MAX_TIMERS + 1);
  localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIV, S_DECIDE, S_EMIT, S_FINAL}
    state_t;

  state_t state;
  mitt_pkg::entry_t tbl [MAX_TIMERS];
  logic [IW-1:0] count, rd, wr;
  logic [1:0] op;
  logic [7:0] own;
  logic [15:0] tid;
  logic found;
  logic [31:0] elapsed, pending, rest;
  logic [15:0] last_id;
  logic div_start, div_done;
  logic [31:0] div_rem;
  mitt_pkg::entry_t cur;
  logic keep, fired;
  logic [31:0] cand;
  logic [31:0] new_rep;
  logic out_free, out_load;
  mitt_pkg::result_t res, res_next;

  mitt_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(elapsed),
    .divisor(cur.period), .done(div_done), .remainder(div_rem)
  );

  assign cur = tbl[rd[AW-1:0]];
  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign m_tuser = res.kind;
  assign m_tdata = {4'b0000, res.delta_ms, res.arm_action, res.out_owner, res.out_id,
                    res.status};
  assign m_tlast = res.last;
  assign div_start = (state == S_SCAN) && (op == mitt_pkg::OP_EXPIRE) &&
                     (rd < count) && (cur.period != 32'd0);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = ((state == S_EMIT) || (state == S_FINAL)) && out_free;

  always_comb begin
    fired = (rest == 32'd0);
    keep = 1'b1;
    cand = cur.period - rest;
    new_rep = cur.repeat_cnt;
    if (fired) begin
      cand = cur.period;
      if (cur.repeat_cnt != mitt_pkg::REPEAT_FOREVER) begin
        new_rep = cur.repeat_cnt - 32'd1;
        keep = (new_rep != 32'd0);
      end
    end
  end

  always_comb begin
    res_next = '0;
    unique case (state)
      S_EMIT: begin
        res_next.kind = mitt_pkg::KIND_FIRE;
        res_next.out_id = cur.id;
        res_next.out_owner = cur.owner;
      end
      S_FINAL: begin
        res_next.last = 1'b1;
        if (op == mitt_pkg::OP_EXPIRE) begin
          res_next.kind = mitt_pkg::KIND_ARM;
          if (pending != 32'd0) begin
            res_next.arm_action = mitt_pkg::ACT_ARM;
            res_next.delta_ms = pending;
          end else begin
            res_next.arm_action = mitt_pkg::ACT_STOP;
          end
        end else begin
          res_next.kind = mitt_pkg::KIND_DEL;
          if (op == mitt_pkg::OP_DEL && !found)
            res_next.status = mitt_pkg::ST_NOT_FOUND;
          else if (rd != '0 && wr == '0)
            res_next.arm_action = mitt_pkg::ACT_STOP;
        end
      end
      default: begin
        res_next.kind = mitt_pkg::KIND_ADD;
        res_next.last = 1'b1;
        if (s_tdata[31:0] == 32'd0) begin
          res_next.status = mitt_pkg::ST_ZERO;
        end else if (count >= IW'(MAX_TIMERS)) begin
          res_next.status = mitt_pkg::ST_FULL;
        end else begin
          res_next.out_id = last_id + 16'd1;
          if (count == '0) begin
            res_next.arm_action = mitt_pkg::ACT_ARM;
            res_next.delta_ms = s_tdata[31:0];
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      elapsed <= '0;
      pending <= '0;
      last_id <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            op <= s_tuser;
            own <= s_tdata[71:64];
            tid <= s_tdata[87:72];
            rd <= '0;
            wr <= '0;
            found <= 1'b0;
            if (s_tuser == mitt_pkg::OP_ADD) begin
              res <= res_next;
              m_tvalid <= 1'b1;
              if (s_tdata[31:0] != 32'd0 && count < IW'(MAX_TIMERS)) begin
                last_id <= last_id + 16'd1;
                tbl[count[AW-1:0]] <= {last_id + 16'd1, s_tdata[71:64],
                                       s_tdata[31:0], s_tdata[63:32]};
                count <= count + IW'(1);
                if (count == '0) pending <= s_tdata[31:0];
              end
            end else begin
              if (s_tuser == mitt_pkg::OP_EXPIRE) begin
                elapsed <= elapsed + pending;
                pending <= '0;
              end
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd >= count) begin
            count <= wr;
            state <= S_FINAL;
          end else if (op != mitt_pkg::OP_EXPIRE) begin
            if (cur.owner == own && (op == mitt_pkg::OP_DEL_ALL ||
                (!found && cur.id == tid))) begin
              found <= 1'b1;
            end else begin
              tbl[wr[AW-1:0]] <= cur;
              wr <= wr + IW'(1);
            end
            rd <= rd + IW'(1);
          end else if (cur.period == 32'd0) begin
            tbl[wr[AW-1:0]] <= cur;
            wr <= wr + IW'(1);
            rd <= rd + IW'(1);
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            rest <= div_rem;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (keep) begin
            tbl[wr[AW-1:0]] <= {cur.id, cur.owner, cur.period, new_rep};
            wr <= wr + IW'(1);
            if (pending == 32'd0 || cand < pending) pending <= cand;
          end
          if (fired) begin
            state <= S_EMIT;
          end else begin
            rd <= rd + IW'(1);
            state <= S_SCAN;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            res <= res_next;
            m_tvalid <= 1'b1;
            rd <= rd + IW'(1);
            state <= S_SCAN;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            res <= res_next;
            m_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ verif/multiplexed_interval_timer_table_core_tb.sv @@
`timescale 1ns / 1ps
module multiplexed_interval_timer_table_core_tb;
  localparam int NT = mitt_pkg::MAX_TIMERS_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40 * NT + 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = '0;
  logic [87:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [1:0]  m_tuser;
  logic [63:0] m_tdata;
  logic        m_tlast;

  multiplexed_interval_timer_table_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always #10 clk = ~clk;

  // timer table shadow
  logic [15:0] tbl_id[NT];
  logic [7:0]  tbl_owner[NT];
  logic [31:0] tbl_period[NT];
  logic [31:0] tbl_repeat[NT];
  int          tbl_cnt = 0;
  logic [31:0] elapsed = '0;
  logic [31:0] pending = '0;
  logic [15:0] last_id = '0;

  mitt_pkg::result_t expected_q[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_fired = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  function automatic mitt_pkg::result_t mk_res(logic [1:0] kind, logic [1:0] status,
                                               logic [15:0] id, logic [7:0] own,
                                               logic [1:0] act, logic [31:0] delta,
                                               logic last);
    mitt_pkg::result_t r;
    r.kind = kind; r.status = status; r.out_id = id; r.out_owner = own;
    r.arm_action = act; r.delta_ms = delta; r.last = last;
    return r;
  endfunction

  task automatic add_expected(mitt_pkg::result_t r);
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic move_entry(int dst, int src);
    tbl_id[dst] = tbl_id[src];
    tbl_owner[dst] = tbl_owner[src];
    tbl_period[dst] = tbl_period[src];
    tbl_repeat[dst] = tbl_repeat[src];
  endtask

  task automatic predict_timers(logic [1:0] op, logic [31:0] per, logic [31:0] rep,
                                logic [7:0] own, logic [15:0] tid);
    int w;
    int n;
    bit found;
    bit hit;
    logic [31:0] rest;
    logic [31:0] cand;
    n = tbl_cnt;
    w = 0;
    found = 0;
    case (op)
      mitt_pkg::OP_ADD: begin
        if (per == 32'd0) begin
          add_expected(mk_res(mitt_pkg::KIND_ADD, mitt_pkg::ST_ZERO, 16'd0, 8'd0,
                              mitt_pkg::ACT_NONE, 32'd0, 1'b1));
        end else if (n >= NT) begin
          add_expected(mk_res(mitt_pkg::KIND_ADD, mitt_pkg::ST_FULL, 16'd0, 8'd0,
                              mitt_pkg::ACT_NONE, 32'd0, 1'b1));
        end else begin
          last_id = last_id + 16'd1;
          tbl_id[n] = last_id; tbl_owner[n] = own;
          tbl_period[n] = per; tbl_repeat[n] = rep;
          tbl_cnt = n + 1;
          if (n == 0) begin
            pending = per;
            add_expected(mk_res(mitt_pkg::KIND_ADD, mitt_pkg::ST_OK, last_id, 8'd0,
                                mitt_pkg::ACT_ARM, per, 1'b1));
          end else begin
            add_expected(mk_res(mitt_pkg::KIND_ADD, mitt_pkg::ST_OK, last_id, 8'd0,
                                mitt_pkg::ACT_NONE, 32'd0, 1'b1));
          end
        end
      end
      mitt_pkg::OP_DEL, mitt_pkg::OP_DEL_ALL: begin
        for (int i = 0; i < n; i++) begin
          hit = tbl_owner[i] == own &&
                (op == mitt_pkg::OP_DEL_ALL || (!found && tbl_id[i] == tid));
          if (hit) begin
            found = 1;
          end else begin
            move_entry(w, i);
            w++;
          end
        end
        tbl_cnt = w;
        if (op == mitt_pkg::OP_DEL && !found)
          add_expected(mk_res(mitt_pkg::KIND_DEL, mitt_pkg::ST_NOT_FOUND, 16'd0, 8'd0,
                              mitt_pkg::ACT_NONE, 32'd0, 1'b1));
        else
          add_expected(mk_res(mitt_pkg::KIND_DEL, mitt_pkg::ST_OK, 16'd0, 8'd0,
                              (n > 0 && w == 0) ? mitt_pkg::ACT_STOP : mitt_pkg::ACT_NONE,
                              32'd0, 1'b1));
      end
      default: begin
        elapsed = elapsed + pending;
        pending = '0;
        for (int i = 0; i < n; i++) begin
          rest = elapsed % tbl_period[i];
          if (rest == 32'd0) begin
            add_expected(mk_res(mitt_pkg::KIND_FIRE, mitt_pkg::ST_OK, tbl_id[i],
                                tbl_owner[i], mitt_pkg::ACT_NONE, 32'd0, 1'b0));
            if (tbl_repeat[i] != mitt_pkg::REPEAT_FOREVER) begin
              tbl_repeat[i] = tbl_repeat[i] - 32'd1;
              if (tbl_repeat[i] == 32'd0) continue;
            end
            cand = tbl_period[i];
          end else begin
            cand = tbl_period[i] - rest;
          end
          if (pending == 32'd0 || cand < pending) pending = cand;
          move_entry(w, i);
          w++;
        end
        tbl_cnt = w;
        if (pending != 32'd0)
          add_expected(mk_res(mitt_pkg::KIND_ARM, mitt_pkg::ST_OK, 16'd0, 8'd0,
                              mitt_pkg::ACT_ARM, pending, 1'b1));
        else
          add_expected(mk_res(mitt_pkg::KIND_ARM, mitt_pkg::ST_OK, 16'd0, 8'd0,
                              mitt_pkg::ACT_STOP, 32'd0, 1'b1));
      end
    endcase
  endtask

  task automatic send_item(logic [1:0] op, logic [31:0] per, logic [31:0] rep,
                           logic [7:0] own, logic [15:0] tid, bit fixed,
                           mitt_pkg::result_t fixed_res);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {tid, own, rep, per};
    do @(posedge clk); while (!s_tready);
    predict_timers(op, per, rep, own, tid);
    if (fixed) expected_q[$] = fixed_res;
    n_items++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver stall pattern: switches at random among four m_tready modes
  int stall_mode = 0;
  int cyc = 0;
  always @(negedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= (cyc % 5) < 2;
      default: m_tready <= $urandom_range(0, 7) == 0;
    endcase
  end

  always @(posedge clk) begin
    mitt_pkg::result_t got;
    mitt_pkg::result_t want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        got = mk_res(m_tuser, m_tdata[1:0], m_tdata[17:2], m_tdata[25:18],
                     m_tdata[27:26], m_tdata[59:28], m_tlast);
        n_results++;
        if (got.kind == mitt_pkg::KIND_FIRE) n_fired++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.kind != want.kind || got.status != want.status ||
              got.out_id != want.out_id || got.out_owner != want.out_owner ||
              got.arm_action != want.arm_action || got.delta_ms != want.delta_ms ||
              got.last != want.last) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, expected_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  typedef struct {
    logic [1:0]        op;
    logic [31:0]       per;
    logic [31:0]       rep;
    logic [7:0]        own;
    logic [15:0]       tid;
    bit                fixed;
    mitt_pkg::result_t res;
  } stim_row_t;

  stim_row_t rows[$];
  mitt_pkg::result_t nores;

  function automatic logic [15:0] pick_id();
    if (tbl_cnt > 0 && $urandom_range(0, 9) < 7) return tbl_id[$urandom_range(0, tbl_cnt - 1)];
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [7:0] pick_owner();
    if ($urandom_range(0, 9) < 8) return 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 32'd0;
    if (r < 84) return $urandom_range(1, 24);
    if (r < 92) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_repeat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(1, 3);
    if (r < 55) return 32'd0;
    if (r < 80) return mitt_pkg::REPEAT_FOREVER;
    return $urandom;
  endfunction

  initial begin
    int r;
    nores = '0;
    rows = '{
      '{mitt_pkg::OP_EXPIRE, 32'd0, 32'd0, 8'd0, 16'd0, 1'b1,
        mk_res(mitt_pkg::KIND_ARM, mitt_pkg::ST_OK, 16'd0, 8'd0, mitt_pkg::ACT_STOP,
               32'd0, 1'b1)},
      '{mitt_pkg::OP_ADD, 32'd0, 32'd5, 8'hFF, 16'd0, 1'b1,
        mk_res(mitt_pkg::KIND_ADD, mitt_pkg::ST_ZERO, 16'd0, 8'd0, mitt_pkg::ACT_NONE,
               32'd0, 1'b1)},
      '{mitt_pkg::OP_DEL, 32'd0, 32'd0, 8'd5, 16'd7, 1'b1,
        mk_res(mitt_pkg::KIND_DEL, mitt_pkg::ST_NOT_FOUND, 16'd0, 8'd0, mitt_pkg::ACT_NONE,
               32'd0, 1'b1)},
      '{mitt_pkg::OP_DEL_ALL, 32'd0, 32'd0, 8'd5, 16'd0, 1'b1,
        mk_res(mitt_pkg::KIND_DEL, mitt_pkg::ST_OK, 16'd0, 8'd0, mitt_pkg::ACT_NONE,
               32'd0, 1'b1)},
      '{mitt_pkg::OP_ADD, 32'd3, 32'd2, 8'hFF, 16'd0, 1'b1,
        mk_res(mitt_pkg::KIND_ADD, mitt_pkg::ST_OK, 16'd1, 8'd0, mitt_pkg::ACT_ARM,
               32'd3, 1'b1)},
      '{mitt_pkg::OP_ADD, 32'd5, 32'd0, 8'd0, 16'd0, 1'b0, nores},
      '{mitt_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 16'd0, 1'b0, nores},
      '{mitt_pkg::OP_ADD, 32'd2, 32'd1, 8'd2, 16'hFFFF, 1'b0, nores},
      '{mitt_pkg::OP_EXPIRE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1'b0, nores},
      '{mitt_pkg::OP_EXPIRE, 32'd0, 32'd0, 8'd0, 16'd0, 1'b0, nores},
      '{mitt_pkg::OP_EXPIRE, 32'd0, 32'd0, 8'd0, 16'd0, 1'b0, nores},
      '{mitt_pkg::OP_EXPIRE, 32'd0, 32'd0, 8'd0, 16'd0, 1'b0, nores},
      '{mitt_pkg::OP_DEL, 32'd0, 32'd0, 8'd2, 16'd3, 1'b0, nores},
      '{mitt_pkg::OP_DEL, 32'd0, 32'd0, 8'd1, 16'd3, 1'b0, nores},
      '{mitt_pkg::OP_DEL_ALL, 32'd0, 32'd0, 8'd0, 16'd0, 1'b0, nores},
      '{mitt_pkg::OP_DEL_ALL, 32'd0, 32'd0, 8'hFF, 16'd0, 1'b0, nores},
      '{mitt_pkg::OP_EXPIRE, 32'd0, 32'd0, 8'd0, 16'd0, 1'b0, nores}
    };
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i])
      send_item(rows[i].op, rows[i].per, rows[i].rep, rows[i].own, rows[i].tid,
                rows[i].fixed, rows[i].res);
    for (int k = 0; k < 386; k++) begin
      if (k % 100 == 50) wait_drained();
      if (k == 200) begin
        repeat (NT + 1)
          send_item(mitt_pkg::OP_ADD, $urandom_range(1, 30), pick_repeat(), pick_owner(),
                    16'd0, 1'b0, nores);
      end
      r = $urandom_range(0, 99);
      if (r < 35)
        send_item(mitt_pkg::OP_ADD, pick_period(), pick_repeat(), pick_owner(),
                  16'($urandom), 1'b0, nores);
      else if (r < 50)
        send_item(mitt_pkg::OP_DEL, $urandom, $urandom, pick_owner(), pick_id(), 1'b0, nores);
      else if (r < 58)
        send_item(mitt_pkg::OP_DEL_ALL, $urandom, $urandom, pick_owner(), 16'($urandom),
                  1'b0, nores);
      else
        send_item(mitt_pkg::OP_EXPIRE, $urandom, $urandom, 8'($urandom), 16'($urandom),
                  1'b0, nores);
    end
    wait_drained();
    $display("Sent %0d items (adds, deletes, owner purges, expiries); checked %0d results,",
             n_items, n_results);
    $display("%0d of them timer firings, final elapsed time %0d ms.", n_fired, elapsed);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
